@@ sv/brfifo_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// brfifo_pkg
// Shared types, codes and sizes for the byte ring FIFO.
// ---------------------------------------------------------------------------
package brfifo_pkg;

  localparam int CAPACITY = 4096;
  localparam int MAX_READ = 64;

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int PTR_W  = ADDR_W + 1;
  localparam int LEN_W  = 13;
  localparam int CNT_W  = $clog2(MAX_READ + 1);
  localparam int CMP_W  = (PTR_W > LEN_W) ? PTR_W : LEN_W;
  localparam int OUT_W  = 13;

  typedef enum logic [2:0] {
    ACT_WRITE_OPEN = 3'd0,
    ACT_WRITE_BYTE = 3'd1,
    ACT_READ       = 3'd2,
    ACT_PEEK       = 3'd3,
    ACT_CONSUME    = 3'd4,
    ACT_QUERY      = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NO_ROOM     = 3'd1,
    ST_SHORT_DATA  = 3'd2,
    ST_OVERCONSUME = 3'd3,
    ST_TOO_LONG    = 3'd4,
    ST_STRAY_BYTE  = 3'd5
  } status_t;

  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_READ = 1'b1
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic rd_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic rd_go;
    logic rd_last;
  } dp_sts_t;

endpackage
`default_nettype wire

@@ sv/brfifo_ram.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// brfifo_ram
// Generic single-port RAM, one write or one read per cycle, registered read.
// ---------------------------------------------------------------------------
module brfifo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

@@ sv/brfifo_ctrl.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// brfifo_ctrl
// Controller: accepts items and sequences the byte stream of read and peek.
// ---------------------------------------------------------------------------
module brfifo_ctrl import brfifo_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  input  wire dp_sts_t sts,
  output logic         busy,
  output ctrl_cmd_t    cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CS_IDLE: begin
        if (start && sts.rd_go) begin
          state_nxt = CS_READ;
        end
      end
      CS_READ: begin
        if (sts.rd_last) begin
          state_nxt = CS_IDLE;
        end
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

  always_comb begin
    busy        = 1'b1;
    cmd.accept  = 1'b0;
    cmd.rd_step = 1'b0;
    case (state_r)
      CS_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
      end
      CS_READ: begin
        cmd.rd_step = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

endmodule
`default_nettype wire

@@ sv/brfifo_dp.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// brfifo_dp
// Datapath: pointers, reservation state, byte store and result registers.
// ---------------------------------------------------------------------------
module brfifo_dp import brfifo_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ctrl_cmd_t        cmd,
  output dp_sts_t               sts,
  input  wire logic [2:0]       in_action,
  input  wire logic [LEN_W-1:0] in_length,
  input  wire logic [7:0]       in_data_byte,
  output logic                  out_valid,
  output logic [2:0]            out_status,
  output logic [7:0]            out_data_out,
  output logic                  out_last_out,
  output logic [OUT_W-1:0]      out_available,
  output logic [OUT_W-1:0]      out_space
);

  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [PTR_W-1:0] stage_r, stage_nxt;
  logic [LEN_W-1:0] pend_r, pend_nxt;
  logic             wip_r, wip_nxt;

  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0] rd_len_r, rd_len_nxt;

  logic             valid_r, valid_nxt;
  status_t          status_r, status_nxt;
  logic             last_r, last_nxt;
  logic             bmode_r, bmode_nxt;
  logic [OUT_W-1:0] avail_r, avail_nxt;
  logic [OUT_W-1:0] space_r, space_nxt;

  logic [PTR_W-1:0] av_cur, sp_cur, av_new, sp_new;
  logic [CMP_W-1:0] len_c, av_c, sp_c;
  logic             is_rd, rd_go, rd_last, ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [7:0]       ram_rdata;
  status_t          st_c;

  assign av_cur = head_r - tail_r;
  assign sp_cur = PTR_W'(CAPACITY) - av_cur;
  assign len_c  = CMP_W'(in_length);
  assign av_c   = CMP_W'(av_cur);
  assign sp_c   = CMP_W'(sp_cur);

  assign is_rd   = (in_action == ACT_READ) || (in_action == ACT_PEEK);
  assign rd_go   = is_rd && (len_c != '0) && (len_c <= CMP_W'(MAX_READ)) && (len_c <= av_c);
  assign rd_last = (rd_idx_r == rd_len_r - CNT_W'(1));

  assign sts.rd_go   = rd_go;
  assign sts.rd_last = rd_last;

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    stage_nxt  = stage_r;
    pend_nxt   = pend_r;
    wip_nxt    = wip_r;
    rd_ptr_nxt = rd_ptr_r;
    rd_idx_nxt = rd_idx_r;
    rd_len_nxt = rd_len_r;
    ram_we     = 1'b0;
    st_c       = ST_OK;

    if (cmd.accept) begin
      case (in_action)
        ACT_WRITE_OPEN: begin
          wip_nxt  = 1'b0;
          pend_nxt = '0;
          if (len_c == '0) begin
            st_c = ST_OK;
          end else if (len_c > sp_c) begin
            st_c = ST_NO_ROOM;
          end else begin
            stage_nxt = head_r;
            pend_nxt  = in_length;
            wip_nxt   = 1'b1;
          end
        end
        ACT_WRITE_BYTE: begin
          if (!wip_r) begin
            st_c = ST_STRAY_BYTE;
          end else begin
            ram_we    = 1'b1;
            stage_nxt = stage_r + PTR_W'(1);
            pend_nxt  = pend_r - LEN_W'(1);
            if (pend_r == LEN_W'(1)) begin
              head_nxt = stage_r + PTR_W'(1);
              wip_nxt  = 1'b0;
            end
          end
        end
        ACT_READ, ACT_PEEK: begin
          if (len_c == '0) begin
            st_c = ST_OK;
          end else if (len_c > CMP_W'(MAX_READ)) begin
            st_c = ST_TOO_LONG;
          end else if (len_c > av_c) begin
            st_c = ST_SHORT_DATA;
          end else begin
            rd_ptr_nxt = tail_r;
            rd_idx_nxt = '0;
            rd_len_nxt = CNT_W'(in_length);
            if (in_action == ACT_READ) begin
              tail_nxt = tail_r + PTR_W'(in_length);
            end
          end
        end
        ACT_CONSUME: begin
          if (len_c > av_c) begin
            st_c = ST_OVERCONSUME;
          end else begin
            tail_nxt = tail_r + PTR_W'(in_length);
          end
        end
        default: st_c = ST_OK;
      endcase
    end else if (cmd.rd_step) begin
      rd_ptr_nxt = rd_ptr_r + PTR_W'(1);
      rd_idx_nxt = rd_idx_r + CNT_W'(1);
    end
  end

  assign av_new = head_nxt - tail_nxt;
  assign sp_new = PTR_W'(CAPACITY) - av_new;

  always_comb begin
    valid_nxt  = 1'b0;
    status_nxt = ST_OK;
    last_nxt   = 1'b1;
    bmode_nxt  = 1'b0;
    avail_nxt  = OUT_W'(av_new);
    space_nxt  = OUT_W'(sp_new);
    if (cmd.accept) begin
      valid_nxt  = !rd_go;
      status_nxt = st_c;
    end else if (cmd.rd_step) begin
      valid_nxt = 1'b1;
      last_nxt  = rd_last;
      bmode_nxt = 1'b1;
    end
  end

  assign ram_addr = cmd.rd_step ? rd_ptr_r[ADDR_W-1:0] : stage_r[ADDR_W-1:0];

  brfifo_ram #(
    .WIDTH (8),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_data_byte),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      stage_r <= '0;
      pend_r  <= '0;
      wip_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      stage_r <= stage_nxt;
      pend_r  <= pend_nxt;
      wip_r   <= wip_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr_r <= rd_ptr_nxt;
    rd_idx_r <= rd_idx_nxt;
    rd_len_r <= rd_len_nxt;
    status_r <= status_nxt;
    last_r   <= last_nxt;
    bmode_r  <= bmode_nxt;
    avail_r  <= avail_nxt;
    space_r  <= space_nxt;
  end

  assign out_valid     = valid_r;
  assign out_status    = status_r;
  assign out_data_out  = bmode_r ? ram_rdata : 8'd0;
  assign out_last_out  = last_r;
  assign out_available = avail_r;
  assign out_space     = space_r;

endmodule
`default_nettype wire

@@ sv/byte_ring_fifo_top.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// byte_ring_fifo_top
// Single-producer, single-consumer byte ring FIFO with reserved writes.
//
//   channel | handshake              | payload
//   --------+------------------------+------------------------------------
//   in      | start, busy            | in_action, in_length, in_data_byte
//   out     | out_valid (strobe)     | out_status, out_data_out,
//           |                        | out_last_out, out_available, out_space
//
// An item is taken when start is high and busy is low; its result shows in the
// next cycle. A streaming read or peek instead moves the controller to its read
// state, and each byte then passes the registered RAM read before its strobe.
// Other items do not raise busy. A read or peek holds busy until its last
// byte is read, one byte per cycle from the single RAM port.
// rst_n is synchronous; the byte store is not cleared. Results are not
// stalled: each is valid for its single strobe cycle.
// ---------------------------------------------------------------------------
module byte_ring_fifo_top import brfifo_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [2:0]       in_action,
  input  wire logic [LEN_W-1:0] in_length,
  input  wire logic [7:0]       in_data_byte,
  output logic                  out_valid,
  output logic [2:0]            out_status,
  output logic [7:0]            out_data_out,
  output logic                  out_last_out,
  output logic [OUT_W-1:0]      out_available,
  output logic [OUT_W-1:0]      out_space
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  brfifo_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  brfifo_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_action     (in_action),
    .in_length     (in_length),
    .in_data_byte  (in_data_byte),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_data_out  (out_data_out),
    .out_last_out  (out_last_out),
    .out_available (out_available),
    .out_space     (out_space)
  );

endmodule
`default_nettype wire
